@@ sv/sdr_pkg.sv @@
package sdr_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned CNT_W       = 16;

  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] CMD17_BYTE  = 8'h51;
  localparam logic [7:0] CRC7_DUMMY  = 8'h01;
  localparam logic [7:0] TOKEN_START = 8'hFE;

  localparam logic [1:0] CFG_BLOCK_ADDRESSED  = 2'd0;
  localparam logic [1:0] CFG_BREATH_BYTES     = 2'd1;
  localparam logic [1:0] CFG_TOKEN_WAIT_LIMIT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CMD_ECHO  = 3'd1;
  localparam logic [2:0] ST_ARG_ECHO  = 3'd2;
  localparam logic [2:0] ST_CRC_ECHO  = 3'd3;
  localparam logic [2:0] ST_TIMEOUT   = 3'd4;
  localparam logic [2:0] ST_ERR_TOKEN = 3'd5;
  localparam logic [2:0] ST_UNEXP_TOK = 3'd6;

  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_PRE    = 10'b00_0000_0010,
    PH_CMD    = 10'b00_0000_0100,
    PH_ARG    = 10'b00_0000_1000,
    PH_CRC7   = 10'b00_0001_0000,
    PH_WAIT   = 10'b00_0010_0000,
    PH_DATA   = 10'b00_0100_0000,
    PH_CRC_HI = 10'b00_1000_0000,
    PH_CRC_LO = 10'b01_0000_0000,
    PH_POST   = 10'b10_0000_0000
  } phase_t;

endpackage

@@ sv/sdr_in_if.sv @@
interface sdr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] byte_address;
  logic [7:0]  rx_byte;

  modport source (output valid, mode, byte_address, rx_byte, input ready);
  modport sink (input valid, mode, byte_address, rx_byte, output ready);
endinterface

@@ sv/sdr_out_if.sv @@
interface sdr_out_if;
  logic        valid;
  logic        ready;
  logic        need_exchange;
  logic [7:0]  tx_byte;
  logic        select_active;
  logic [7:0]  data_byte;
  logic        data_valid;
  logic        data_last;
  logic        done_res;
  logic [2:0]  status;
  logic [3:0]  error_token;
  logic [15:0] block_crc;

  modport source (output valid, need_exchange, tx_byte, select_active, data_byte,
                  data_valid, data_last, done_res, status, error_token, block_crc,
                  input ready);
  modport sink (input valid, need_exchange, tx_byte, select_active, data_byte,
                data_valid, data_last, done_res, status, error_token, block_crc,
                output ready);
endinterface

@@ sv/sd_spi_single_block_read.sv @@
// SD card SPI host engine for one single-block read (CMD17).
// in_ch carries words: mode 0 starts a read at byte_address, mode 1 reports a
// completed SPI byte exchange with the byte received in rx_byte. Every accepted
// word yields exactly one result word on out_ch: the next exchange request
// (need_exchange, tx_byte, select_active), a streamed block byte (data_byte,
// data_valid, data_last) and, at the end, done_res with status, error_token and
// block_crc.
// cfg_we/cfg_index/cfg_wdata write block_addressed, breath_bytes and
// token_wait_limit; write them only while no transaction is running.
// The result of a word sits in the output register on the cycle after it is
// accepted. Throughput is one word per cycle while out_ch is not stalled, set by
// the single phase update between the input handshake and the output register.
// When the receiver stalls, the output register holds its word and in_ch.ready
// drops until that word is taken; ready is high in the same cycle it is taken.
// Reset empties the output register, returns the engine to idle and loads the
// registers with 0, 10 and 256.
module sd_spi_single_block_read import sdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  sdr_in_if.sink      in_ch,
  sdr_out_if.source   out_ch
);

  logic              blk_addr_r;
  logic [7:0]        breath_r;
  logic [15:0]       wait_lim_r;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [15:0]       crc_r, crc_nxt;

  logic              out_valid_r;
  logic              need_r, sel_r, dv_r, dl_r, done_r;
  logic [7:0]        tx_r, db_r;
  logic [2:0]        st_r;
  logic [3:0]        tok_r;
  logic [15:0]       bcrc_r;

  logic              accept;
  logic [CNT_W:0]    cnt_inc;
  logic [15:0]       lim;
  logic              fin;
  logic [2:0]        st;
  logic [3:0]        tok;
  logic              dv, dl;
  logic [7:0]        db;
  logic [7:0]        tx;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cnt_inc     = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign lim         = (wait_lim_r == 16'd0) ? 16'd1 : wait_lim_r;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    crc_nxt   = crc_r;
    fin       = 1'b0;
    st        = ST_OK;
    tok       = 4'd0;
    dv        = 1'b0;
    dl        = 1'b0;
    db        = 8'd0;
    if (!in_ch.mode) begin
      // a start while busy only repeats the pending request
      if (phase_r == PH_IDLE) begin
        addr_nxt  = blk_addr_r ? {9'd0, in_ch.byte_address[31:9]} : in_ch.byte_address;
        crc_nxt   = 16'd0;
        cnt_nxt   = '0;
        phase_nxt = (breath_r != 8'd0) ? PH_PRE : PH_CMD;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_PRE: begin
          if (cnt_inc >= {9'd0, breath_r}) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CMD;
          end else begin
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end
        end
        PH_CMD: begin
          if (in_ch.rx_byte != BYTE_IDLE) begin
            fin = 1'b1;
            st  = ST_CMD_ECHO;
          end else begin
            cnt_nxt   = '0;
            phase_nxt = PH_ARG;
          end
        end
        PH_ARG: begin
          if (in_ch.rx_byte != BYTE_IDLE) begin
            fin = 1'b1;
            st  = ST_ARG_ECHO;
          end else if (cnt_r[1:0] == 2'd3) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CRC7;
          end else begin
            cnt_nxt = {{(CNT_W-2){1'b0}}, cnt_r[1:0] + 2'd1};
          end
        end
        PH_CRC7: begin
          if (in_ch.rx_byte != BYTE_IDLE) begin
            fin = 1'b1;
            st  = ST_CRC_ECHO;
          end else begin
            cnt_nxt   = '0;
            phase_nxt = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (in_ch.rx_byte != BYTE_ZERO && in_ch.rx_byte != BYTE_IDLE) begin
            if (in_ch.rx_byte == TOKEN_START) begin
              cnt_nxt   = '0;
              phase_nxt = PH_DATA;
            end else if (in_ch.rx_byte[7:4] == 4'd0) begin
              fin = 1'b1;
              st  = ST_ERR_TOKEN;
              tok = in_ch.rx_byte[3:0];
            end else begin
              fin = 1'b1;
              st  = ST_UNEXP_TOK;
            end
          end else if (cnt_inc >= {1'b0, lim}) begin
            fin = 1'b1;
            st  = (in_ch.rx_byte == BYTE_IDLE) ? ST_TIMEOUT : ST_ERR_TOKEN;
          end else begin
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end
        end
        PH_DATA: begin
          db = in_ch.rx_byte;
          dv = 1'b1;
          if (cnt_inc >= (CNT_W+1)'(BLOCK_BYTES)) begin
            dl        = 1'b1;
            cnt_nxt   = '0;
            phase_nxt = PH_CRC_HI;
          end else begin
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end
        end
        PH_CRC_HI: begin
          crc_nxt   = {in_ch.rx_byte, 8'd0};
          phase_nxt = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_nxt = {crc_r[15:8], in_ch.rx_byte};
          cnt_nxt = '0;
          if (breath_r == 8'd0) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_POST;
          end
        end
        PH_POST: begin
          if (cnt_inc >= {9'd0, breath_r}) begin
            fin = 1'b1;
          end else begin
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end
    if (fin) begin
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
    end
  end

  // byte to send in the exchange that the new phase asks for
  always_comb begin
    case (phase_nxt)
      PH_IDLE: tx = 8'd0;
      PH_CMD:  tx = CMD17_BYTE;
      PH_CRC7: tx = CRC7_DUMMY;
      PH_ARG: begin
        case (cnt_nxt[1:0])
          2'd0:    tx = addr_nxt[31:24];
          2'd1:    tx = addr_nxt[23:16];
          2'd2:    tx = addr_nxt[15:8];
          default: tx = addr_nxt[7:0];
        endcase
      end
      default: tx = BYTE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_addr_r <= 1'b0;
      breath_r   <= 8'd10;
      wait_lim_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_ADDRESSED:  blk_addr_r <= cfg_wdata[0];
        CFG_BREATH_BYTES:     breath_r   <= cfg_wdata[7:0];
        CFG_TOKEN_WAIT_LIMIT: wait_lim_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      addr_r      <= 32'd0;
      crc_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        cnt_r       <= cnt_nxt;
        addr_r      <= addr_nxt;
        crc_r       <= crc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      need_r <= (phase_nxt != PH_IDLE);
      sel_r  <= (phase_nxt != PH_IDLE);
      tx_r   <= tx;
      db_r   <= db;
      dv_r   <= dv;
      dl_r   <= dl;
      done_r <= fin;
      st_r   <= st;
      tok_r  <= tok;
      bcrc_r <= fin ? crc_nxt : 16'd0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.need_exchange = need_r;
  assign out_ch.tx_byte       = tx_r;
  assign out_ch.select_active = sel_r;
  assign out_ch.data_byte     = db_r;
  assign out_ch.data_valid    = dv_r;
  assign out_ch.data_last     = dl_r;
  assign out_ch.done_res      = done_r;
  assign out_ch.status        = st_r;
  assign out_ch.error_token   = tok_r;
  assign out_ch.block_crc     = bcrc_r;

endmodule
